### design/sobel_pkg.sv
// Shared types, constants and functions for the Sobel edge magnitude block.
package sobel_pkg;

	typedef struct packed {
		logic       operation;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_edge;
		logic [7:0] green_edge;
		logic [7:0] blue_edge;
		logic       end_of_row;
		logic       end_of_frame;
	} pix_out_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam int CFG_W = 13;
	localparam logic [16:0] SAT_LIMIT = 17'd65281;

	// One window job: nine pixels plus the output flags.
	typedef struct packed {
		logic [8:0][23:0] win;
		logic             eor;
		logic             eof;
	} job_t;

	// Gradient of one channel; kernel rows as in the usual Sobel pair.
	function automatic logic signed [11:0] grad_x(input logic [8:0][7:0] p);
		grad_x = -$signed({4'd0, p[0]}) + $signed({4'd0, p[2]})
			- $signed({3'd0, p[3], 1'b0}) + $signed({3'd0, p[5], 1'b0})
			- $signed({4'd0, p[6]}) + $signed({4'd0, p[8]});
	endfunction

	function automatic logic signed [11:0] grad_y(input logic [8:0][7:0] p);
		grad_y = -$signed({4'd0, p[0]}) - $signed({3'd0, p[1], 1'b0})
			- $signed({4'd0, p[2]}) + $signed({4'd0, p[6]})
			+ $signed({3'd0, p[7], 1'b0}) + $signed({4'd0, p[8]});
	endfunction

endpackage

### design/sobel_front.sv
// Front end: counters, line stores and window; issues window jobs.
module sobel_front import sobel_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  pix_in_t     in_data,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT, S_EXTRA} state_t;

	state_t state_q;
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [23:0] px_q;
	logic [23:0] upper_mem [MAX_WIDTH];
	logic [23:0] middle_mem [MAX_WIDTH];
	logic [23:0] top_rd_q, mid_rd_q;
	logic [8:0][23:0] win_q;
	logic flush_q, last_q;

	// Clamped configuration.
	logic [CW:0] w_eff;
	logic [RW:0] h_eff;
	always_comb begin
		if (width_q == 11'd0) w_eff = (CW+1)'(1);
		else if ({21'd0, width_q} > 32'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
		else w_eff = (CW+1)'(width_q);
		if (height_q == 13'd0) h_eff = (RW+1)'(1);
		else if ({19'd0, height_q} > 32'(MAX_HEIGHT)) h_eff = (RW+1)'(MAX_HEIGHT);
		else h_eff = (RW+1)'(height_q);
	end

	logic flush_row, last_col;
	assign flush_row = {1'b0, row_q} >= h_eff;
	assign last_col  = {1'b0, col_q} >= w_eff - (CW+1)'(1);
	assign in_ready  = (state_q == S_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd768;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) width_q <= cfg_data[10:0];
			else if (cfg_index == REG_HEIGHT) height_q <= cfg_data;
		end
	end

	// Line store read and write-back, one port each per transaction.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			top_rd_q <= upper_mem[col_q];
			mid_rd_q <= middle_mem[col_q];
		end
		if (state_q == S_READ) begin
			upper_mem[col_q]  <= mid_rd_q;
			middle_mem[col_q] <= px_q;
		end
	end

	// Window with the new column shifted in.
	logic [8:0][23:0] win_new;
	logic [23:0] top_v, mid_v;
	always_comb begin
		top_v = (row_q >= RW'(2)) ? top_rd_q : 24'd0;
		mid_v = (row_q >= RW'(1)) ? mid_rd_q : 24'd0;
		win_new = (col_q == '0) ? '0 : win_q;
		win_new[0] = win_new[1]; win_new[1] = win_new[2]; win_new[2] = top_v;
		win_new[3] = win_new[4]; win_new[4] = win_new[5]; win_new[5] = mid_v;
		win_new[6] = win_new[7]; win_new[7] = win_new[8]; win_new[8] = px_q;
	end

	// Sequencer: accept, read stores, emit up to two jobs, advance counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			win_q     <= '0;
			job_valid <= 1'b0;
			flush_q   <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						px_q <= (in_data.operation || flush_row) ? 24'd0 :
							{in_data.red_in, in_data.green_in, in_data.blue_in};
						flush_q <= flush_row;
						last_q  <= last_col;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					win_q <= win_new;
					if (row_q != '0 && col_q != '0) begin
						job_valid <= 1'b1;
						job <= '{win: win_new, eor: 1'b0, eof: 1'b0};
						state_q <= S_EMIT;
					end else if (row_q != '0 && last_q) begin
						job_valid <= 1'b1;
						job <= '{win: {24'd0, win_new[8:7], 24'd0, win_new[5:4],
							24'd0, win_new[2:1]}, eor: 1'b1, eof: flush_q};
						state_q <= S_EXTRA;
					end else begin
						state_q <= S_EXTRA;
					end
				end
				S_EMIT: begin
					if (job_ready) begin
						if (last_q) begin
							job <= '{win: {24'd0, win_q[8:7], 24'd0, win_q[5:4],
								24'd0, win_q[2:1]}, eor: 1'b1, eof: flush_q};
							state_q <= S_EXTRA;
						end else begin
							job_valid <= 1'b0;
							state_q <= S_EXTRA;
						end
					end
				end
				S_EXTRA: begin
					if (!job_valid || job_ready) begin
						job_valid <= 1'b0;
						if (last_q) begin
							col_q <= '0;
							row_q <= flush_q ? '0 : row_q + RW'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/sobel_queue.sv
// Short FIFO between the front end and the magnitude back end.
module sobel_queue import sobel_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### design/sobel_back.sv
// Back end: gradients, exact rounded square root and output register.
module sobel_back import sobel_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	output logic     job_ready,
	input  job_t     job,
	output logic     out_valid,
	input  logic     out_ready,
	output pix_out_t out_data
);
	typedef enum logic [1:0] {B_IDLE, B_SQR, B_ROOT, B_OUT} state_t;

	state_t state_q;
	logic [2:0][20:0] s_q;
	logic [2:0][8:0] n_q;
	logic signed [2:0][11:0] gx_q, gy_q;
	logic [3:0] bit_q;
	logic eor_q, eof_q;

	assign job_ready = (state_q == B_IDLE);

	// Per-channel gradients from the window.
	logic [2:0][8:0][7:0] chan;
	always_comb begin
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 9; i++)
				chan[k][i] = job.win[i][23-8*k -: 8];
	end

	// Gradient energy per channel; the sum of squares needs 21 bits.
	logic signed [23:0] gx_sq [3];
	logic signed [23:0] gy_sq [3];
	logic [2:0][20:0] energy;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			gx_sq[k] = $signed(gx_q[k]) * $signed(gx_q[k]);
			gy_sq[k] = $signed(gy_q[k]) * $signed(gy_q[k]);
			energy[k] = 21'(gx_sq[k]) + 21'(gy_sq[k]);
		end
	end

	// One root bit per cycle for all three channels.
	logic [2:0][8:0] trial;
	logic [2:0][17:0] tsq;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			trial[k] = n_q[k] | (9'd1 << bit_q);
			tsq[k] = 18'(trial[k]) * 18'(trial[k]);
		end
	end

	logic [2:0][7:0] res;
	logic [2:0][20:0] rem;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rem[k] = s_q[k] - 21'(18'(n_q[k]) * 18'(n_q[k]));
			if (s_q[k] >= 21'(SAT_LIMIT)) res[k] = 8'd255;
			else if (rem[k] > 21'(n_q[k])) res[k] = 8'(n_q[k] + 9'd1);
			else res[k] = n_q[k][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						for (int k = 0; k < 3; k++) begin
							gx_q[k] <= grad_x(chan[k]);
							gy_q[k] <= grad_y(chan[k]);
						end
						eor_q <= job.eor; eof_q <= job.eof;
						state_q <= B_SQR;
					end
				end
				B_SQR: begin
					for (int k = 0; k < 3; k++) begin
						s_q[k] <= energy[k];
						n_q[k] <= '0;
					end
					bit_q <= 4'd8;
					state_q <= B_ROOT;
				end
				B_ROOT: begin
					for (int k = 0; k < 3; k++)
						if (21'(tsq[k]) <= s_q[k]) n_q[k] <= trial[k];
					if (bit_q == 4'd0) state_q <= B_OUT;
					else bit_q <= bit_q - 4'd1;
				end
				B_OUT: begin
					if (!out_valid || out_ready) begin
						out_data <= '{red_edge: res[0], green_edge: res[1],
							blue_edge: res[2], end_of_row: eor_q, end_of_frame: eof_q};
						out_valid <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (out_valid && out_ready && !(state_q == B_OUT)) out_valid <= 1'b0;
		end
	end
endmodule

### design/sobel_edge_magnitude_3x3.sv
// The front end accepts a new input transaction only when it is idle again after the last one;
// the back end takes a new job only when idle, and each result's time there is set by the
// bit-serial square root.
// The line stores have no reset; reset clears counters, window and the queue.
// Configuration resets to width 1024 and height 768.
module sobel_edge_magnitude_3x3 import sobel_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  pix_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pix_out_t    out_data
);
	logic fv, fr, qv, qr;
	job_t fj, qj;

	sobel_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
		.in_data, .job_valid(fv), .job_ready(fr), .job(fj));

	sobel_queue u_queue (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qj));

	sobel_back u_back (.clk, .arst_n, .job_valid(qv), .job_ready(qr), .job(qj),
		.out_valid, .out_ready, .out_data);
endmodule

### tb/sobel_checker.sv
// Edge magnitude predictor and result scoreboard for the Sobel block.
module sobel_checker import sobel_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  pix_in_t          in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  pix_out_t         out_data,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [23:0] upper_row [MAX_WIDTH];
	logic [23:0] middle_row [MAX_WIDTH];
	logic [23:0] window [9];
	int unsigned col_pos;
	int unsigned row_pos;
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	pix_out_t    edge_queue [$];

	assign pending = edge_queue.size();

	// Rounded square root of the gradient energy, saturated at 255.
	function automatic logic [7:0] gradient_magnitude(int gx, int gy);
		int unsigned energy;
		int unsigned root;
		int unsigned trial;
		energy = gx * gx + gy * gy;
		if (energy >= 65281) begin
			return 8'd255;
		end
		root = 0;
		for (int b = 8; b >= 0; b--) begin
			trial = root | (1 << b);
			if (trial * trial <= energy) begin
				root = trial;
			end
		end
		if (energy - root * root > root) begin
			root++;
		end
		return (root > 255) ? 8'd255 : root[7:0];
	endfunction

	// Sobel result for one channel of the current window.
	function automatic logic [7:0] channel_edge(int sh);
		int p [9];
		int gx;
		int gy;
		for (int i = 0; i < 9; i++) begin
			p[i] = (window[i] >> sh) & 8'hFF;
		end
		gx = -p[0] + p[2] - 2 * p[3] + 2 * p[5] - p[6] + p[8];
		gy = -p[0] - 2 * p[1] - p[2] + p[6] + 2 * p[7] + p[8];
		return gradient_magnitude(gx, gy);
	endfunction

	function automatic void shift_column(logic [23:0] t, logic [23:0] m, logic [23:0] b);
		for (int r = 0; r < 3; r++) begin
			window[r*3]   = window[r*3+1];
			window[r*3+1] = window[r*3+2];
		end
		window[2] = t;
		window[5] = m;
		window[8] = b;
	endfunction

	function automatic void push_edge(logic eor, logic eof);
		pix_out_t res;
		res.red_edge     = channel_edge(16);
		res.green_edge   = channel_edge(8);
		res.blue_edge    = channel_edge(0);
		res.end_of_row   = eor;
		res.end_of_frame = eof;
		edge_queue.push_back(res);
	endfunction

	// Advance the window by one input transaction and queue the edges it completes.
	function automatic void predict_edges(pix_in_t item);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		logic        flush_row;
		logic        last_col;
		logic [23:0] px;
		logic [23:0] t;
		logic [23:0] m;
		w = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		h = (height_reg < 1) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
		c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
		r = row_pos;
		flush_row = (r >= h);
		last_col  = (c >= w - 1);
		px = {item.red_in, item.green_in, item.blue_in};
		if (item.operation || flush_row) begin
			px = '0;
		end
		// Rows above the top of the image read as zero.
		t = (r >= 2) ? upper_row[c] : '0;
		m = (r >= 1) ? middle_row[c] : '0;
		upper_row[c]  = middle_row[c];
		middle_row[c] = px;
		if (c == 0) begin
			for (int i = 0; i < 9; i++) window[i] = '0;
		end
		shift_column(t, m, px);
		if (r >= 1) begin
			if (c >= 1) begin
				push_edge(1'b0, 1'b0);
			end
			if (last_col) begin
				shift_column('0, '0, '0);
				push_edge(1'b1, flush_row);
			end
		end
		if (last_col) begin
			col_pos = 0;
			row_pos = flush_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Watch the channels and the register port at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			width_reg  = 11'd1024;
			height_reg = 13'd768;
			col_pos    = 0;
			row_pos    = 0;
			for (int i = 0; i < 9; i++) window[i] = '0;
			edge_queue.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (edge_queue.size() == 0) begin
					report_mismatch("unexpected output transaction", 1, 0);
				end else begin
					want = edge_queue.pop_front();
					if (out_data.red_edge !== want.red_edge)
						report_mismatch("red_edge", int'(out_data.red_edge),
							int'(want.red_edge));
					if (out_data.green_edge !== want.green_edge)
						report_mismatch("green_edge", int'(out_data.green_edge),
							int'(want.green_edge));
					if (out_data.blue_edge !== want.blue_edge)
						report_mismatch("blue_edge", int'(out_data.blue_edge),
							int'(want.blue_edge));
					if (out_data.end_of_row !== want.end_of_row)
						report_mismatch("end_of_row", int'(out_data.end_of_row),
							int'(want.end_of_row));
					if (out_data.end_of_frame !== want.end_of_frame)
						report_mismatch("end_of_frame", int'(out_data.end_of_frame),
							int'(want.end_of_frame));
				end
			end
			if (in_valid && in_ready) begin
				predict_edges(in_data);
			end
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) begin
					width_reg = cfg_data[10:0];
				end else if (cfg_index == REG_HEIGHT) begin
					height_reg = cfg_data[12:0];
				end
			end
		end
	end

endmodule

### tb/testbench.sv
// Stimulus, watchdog and verdict for the Sobel edge magnitude block.
module testbench import sobel_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_UNUSED = 2'd2;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 40;

	typedef enum int {FRAME_RANDOM, FRAME_DIRECTED, FRAME_EXTREME} frame_kind_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	pix_in_t          in_data;
	logic             out_valid;
	logic             out_ready;
	pix_out_t         out_data;
	int               fail_count;
	int               pending;
	logic             quiet;
	int               stall_left;
	int               idle_cycles;
	int               sent_items;

	sobel_edge_magnitude_3x3 u_top (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
	);

	sobel_checker u_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
		.fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls in short random bursts, except in the quiet tail.
	always @(negedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{operation: op, red_in: r, green_in: g, blue_in: b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	// Wait until every expected result is in and the pipeline has drained.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One whole frame of w by h pixels followed by its flush row.
	task automatic run_frame(int w, int h, frame_kind_t kind);
		logic       op;
		logic [7:0] v;
		for (int r = 0; r <= h; r++) begin
			for (int c = 0; c < w; c++) begin
				if (kind == FRAME_DIRECTED) begin
					v  = ((r + c) % 2) ? 8'hFF : 8'h00;
					// A flush inside the image and a pixel inside the flush row.
					op = (r == h) ? (c != 0) : (r == 1 && c == 1);
					send_item(op, v, ~v, v);
				end else if (kind == FRAME_EXTREME) begin
					v = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
					send_item(r == h, v, ~v, 8'($urandom_range(0, 255)));
				end else begin
					op = (r == h) ? ($urandom_range(0, 9) != 0)
						: ($urandom_range(0, 15) == 0);
					send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	task automatic config_frame(int w_reg, int h_reg, int w, int h, frame_kind_t kind);
		wait_idle();
		write_reg(REG_WIDTH, w_reg);
		write_reg(REG_HEIGHT, h_reg);
		run_frame(w, h, kind);
	endtask

	initial begin
		int w;
		int h;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_WIDTH;
		cfg_data   = '0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		quiet      = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		sent_items = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: checkerboard extremes, a tiny frame, and the one-pixel frame.
		config_frame(3, 2, 3, 2, FRAME_DIRECTED);
		config_frame(2, 1, 2, 1, FRAME_EXTREME);
		config_frame(1, 1, 1, 1, FRAME_DIRECTED);
		wait_idle();
		write_reg(REG_UNUSED, 13'h1FFF);
		run_frame(1, 1, FRAME_EXTREME);

		// Register extremes: zero values clamp to one.
		config_frame(0, 0, 1, 1, FRAME_RANDOM);
		config_frame(0, 3, 1, 3, FRAME_EXTREME);
		config_frame(4, 0, 4, 1, FRAME_EXTREME);

		// Random frames, mostly small.
		while (sent_items < 1700) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
			h = $urandom_range(1, 6);
			config_frame(w, h, w, h, FRAME_RANDOM);
		end

		// Quiet tail with both sides running flat out.
		wait_idle();
		quiet = 1'b1;
		for (int k = 0; k < 4; k++) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 5);
			config_frame(w, h, w, h, FRAME_RANDOM);
		end
		wait_idle();

		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
design/sobel_pkg.sv
design/sobel_front.sv
design/sobel_queue.sv
design/sobel_back.sv
design/sobel_edge_magnitude_3x3.sv
tb/sobel_checker.sv
tb/testbench.sv
